FILE: sv/bblur_pkg.sv
// ----------------------------------------------------------------------------
// bblur_pkg: shared types and constants of the 3x3 box blur
// Payload structs, the line buffer and window item types, the configuration
// register codes and the reciprocal table used for the rounded mean.
// ----------------------------------------------------------------------------
package bblur_pkg;

  localparam int MaxWidth   = 1024;
  localparam int MaxHeight  = 1024;
  localparam int QueueDepth = 4;
  localparam int OutDepth   = 4;
  localparam int QueueCntW  = $clog2(QueueDepth + 1);
  localparam int OutCntW    = $clog2(OutDepth + 1);

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 11;
  localparam logic [CfgDataW-1:0] ImageSizeReset = 11'd1024;

  // Sum of nine 8-bit values, neighbour count 1..9, numerator 2*sum+count.
  localparam int SumW       = 12;
  localparam int CntW       = 4;
  localparam int NumW       = 13;
  localparam int RecipW     = 17;
  localparam int RecipShift = 17;
  localparam int ProdW      = NumW + RecipW;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 2'd0,
    CfgImageHeight = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic                valid;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } req_t;

  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       last_of_frame;
  } res_t;

  // Blue in the low byte, red in the high byte.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // One line buffer word: the items one and two rows back in this column.
  typedef struct packed {
    pixel_t older;
    pixel_t newer;
  } lb_entry_t;

  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  typedef struct packed {
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
  } mask_t;

  typedef struct packed {
    column_t left;
    column_t center;
    column_t right;
    mask_t   mask;
    logic    last;
  } job_t;

  // ceil(2^17 / (2*count)); exact floor division for every numerator here.
  function automatic logic [RecipW-1:0] recip(input logic [CntW-1:0] cnt);
    logic [RecipW-1:0] m;
    case (cnt)
      4'd1:    m = RecipW'(65536);
      4'd2:    m = RecipW'(32768);
      4'd3:    m = RecipW'(21846);
      4'd4:    m = RecipW'(16384);
      4'd5:    m = RecipW'(13108);
      4'd6:    m = RecipW'(10923);
      4'd7:    m = RecipW'(9363);
      4'd8:    m = RecipW'(8192);
      4'd9:    m = RecipW'(7282);
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

FILE: sv/bblur_ram.sv
// ----------------------------------------------------------------------------
// bblur_ram: generic single-clock RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bblur_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // A read of the address being written returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/bblur_fifo.sv
// ----------------------------------------------------------------------------
// bblur_fifo: small synchronous queue
// Register-based FIFO with an occupancy count for credit-based flow control.
// ----------------------------------------------------------------------------
module bblur_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [Width-1:0]           data_i,
  input  logic                       pop_i,
  output logic [Width-1:0]           data_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign count_o = count_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: sv/bblur_front.sv
// ----------------------------------------------------------------------------
// bblur_front: intake, frame position tracking, line buffers and window
// Classifies each item, keeps the raster counters, reads and rewrites the
// line buffer word of its column and shifts the three-column window.
// ----------------------------------------------------------------------------
module bblur_front import bblur_pkg::*; #(
  parameter int MAX_WIDTH  = MaxWidth,
  parameter int MAX_HEIGHT = MaxHeight
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_wr_t              cfg_i,
  input  logic                 push_i,
  input  req_t                 req_i,
  output logic                 full_o,
  input  logic [QueueCntW-1:0] q_count_i,
  output logic                 job_push_o,
  output job_t                 job_o
);

  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int EffWW = $clog2(MAX_WIDTH + 1);
  localparam int EffHW = $clog2(MAX_HEIGHT + 1);
  localparam int InRW  = $clog2(MAX_HEIGHT + 2);
  localparam int OutRW = $clog2(MAX_HEIGHT);

  logic [CfgDataW-1:0] width_q, height_q;
  logic [EffWW-1:0]    eff_w;
  logic [EffHW-1:0]    eff_h;
  cfg_idx_e            cfg_idx;

  logic [ColW-1:0]  in_col_q, in_col_d;
  logic [InRW-1:0]  in_row_q, in_row_d;
  logic [ColW-1:0]  out_col_q, out_col_d;
  logic [OutRW-1:0] out_row_q, out_row_d;

  logic   accept, in_frame, emit, last;
  mask_t  mask;
  pixel_t pix;

  // Lookup stage: the item whose line buffer word is being read.
  logic            l_v_q;
  pixel_t          l_pix_q;
  logic [ColW-1:0] l_addr_q;
  logic            l_emit_q, l_last_q;
  mask_t           l_mask_q;
  logic            fwd_q;
  lb_entry_t       fwd_data_q;

  lb_entry_t lb_rdata, lb_rd, lb_wr;
  column_t   cur_col;
  column_t   col1_q, col2_q;

  assign cfg_idx = cfg_idx_e'(cfg_i.index);

  always_comb begin
    if (width_q == '0) begin
      eff_w = EffWW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_w = EffWW'(MAX_WIDTH);
    end else begin
      eff_w = EffWW'(width_q);
    end
    if (height_q == '0) begin
      eff_h = EffHW'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      eff_h = EffHW'(MAX_HEIGHT);
    end else begin
      eff_h = EffHW'(height_q);
    end
  end

  assign full_o = (int'(q_count_i) + int'(l_v_q)) >= QueueDepth;
  assign accept = push_i && !full_o;

  always_comb begin
    in_frame = 32'(in_row_q) < 32'(eff_h);
    pix = '0;
    if (!req_i.req_type && in_frame) begin
      pix.blue  = req_i.blue_in;
      pix.green = req_i.green_in;
      pix.red   = req_i.red_in;
    end
    emit = (32'(in_row_q) >= 32'd2) || ((32'(in_row_q) == 32'd1) && (in_col_q != '0));
    last = emit && (32'(out_row_q) + 32'd1 == 32'(eff_h))
                && (32'(out_col_q) + 32'd1 == 32'(eff_w));
    mask.top_ok   = (out_row_q != '0);
    mask.bot_ok   = (32'(out_row_q) + 32'd1) < 32'(eff_h);
    mask.left_ok  = (out_col_q != '0);
    mask.right_ok = (32'(out_col_q) + 32'd1) < 32'(eff_w);

    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (last) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else begin
      if ((32'(in_col_q) + 32'd1) >= 32'(eff_w)) begin
        in_col_d = '0;
        in_row_d = in_row_q + InRW'(1);
      end else begin
        in_col_d = in_col_q + ColW'(1);
      end
      if (emit) begin
        if ((32'(out_col_q) + 32'd1) >= 32'(eff_w)) begin
          out_col_d = '0;
          out_row_d = out_row_q + OutRW'(1);
        end else begin
          out_col_d = out_col_q + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= ImageSizeReset;
      height_q  <= ImageSizeReset;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_idx)
        CfgImageWidth: begin
          width_q   <= cfg_i.data;
          in_col_q  <= '0;
          in_row_q  <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
        end
        CfgImageHeight: begin
          height_q  <= cfg_i.data;
          in_col_q  <= '0;
          in_row_q  <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_v_q <= 1'b0;
    end else begin
      l_v_q <= accept;
    end
  end

  // The word written by the lookup stage in the cycle of a read at the same
  // column (a one-pixel-wide frame) is passed on directly.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      l_pix_q    <= pix;
      l_addr_q   <= in_col_q;
      l_emit_q   <= emit;
      l_last_q   <= last;
      l_mask_q   <= mask;
      fwd_q      <= l_v_q && (l_addr_q == in_col_q);
      fwd_data_q <= lb_wr;
    end
    if (l_v_q) begin
      col1_q <= cur_col;
      col2_q <= col1_q;
    end
  end

  bblur_ram #(
    .Width($bits(lb_entry_t)),
    .Depth(MAX_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (l_v_q),
    .waddr_i(l_addr_q),
    .wdata_i(lb_wr),
    .re_i   (accept),
    .raddr_i(in_col_q),
    .rdata_o(lb_rdata)
  );

  always_comb begin
    lb_rd          = fwd_q ? fwd_data_q : lb_rdata;
    lb_wr.older    = lb_rd.newer;
    lb_wr.newer    = l_pix_q;
    cur_col.top    = lb_rd.older;
    cur_col.mid    = lb_rd.newer;
    cur_col.bot    = l_pix_q;
    job_o.left     = col2_q;
    job_o.center   = col1_q;
    job_o.right    = cur_col;
    job_o.mask     = l_mask_q;
    job_o.last     = l_last_q;
  end

  assign job_push_o = l_v_q && l_emit_q;

endmodule

FILE: sv/bblur_back.sv
// ----------------------------------------------------------------------------
// bblur_back: neighbourhood sums and rounded means
// Sums the in-image pixels of a window, then divides by the neighbour count
// with a reciprocal multiply; results go to the output queue.
// ----------------------------------------------------------------------------
module bblur_back import bblur_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  job_t               job_i,
  output logic               job_pop_o,
  input  logic [OutCntW-1:0] o_count_i,
  output logic               res_push_o,
  output res_t               res_o
);

  logic [2:0][2:0][23:0] win;
  logic [2:0]            row_ok, col_ok;
  logic [2:0][SumW-1:0]  sum_d;
  logic [SumW-1:0]       colsum;
  logic [CntW-1:0]       cnt_d;
  logic [2:0][7:0]       px;

  logic                 b1_v_q, b2_v_q;
  logic [2:0][SumW-1:0] b1_sum_q;
  logic [CntW-1:0]      b1_cnt_q;
  logic                 b1_last_q, b2_last_q;
  logic [2:0][ProdW-1:0] b2_prod_q;
  logic [2:0][NumW-1:0]  num;

  // Take a window only when the output queue has room for everything in flight.
  assign job_pop_o = job_valid_i &&
                     ((int'(o_count_i) + int'(b1_v_q) + int'(b2_v_q)) < OutDepth);

  always_comb begin
    win[0] = job_i.right;
    win[1] = job_i.center;
    win[2] = job_i.left;
    row_ok = {job_i.mask.top_ok, 1'b1, job_i.mask.bot_ok};
    col_ok = {job_i.mask.left_ok, 1'b1, job_i.mask.right_ok};
    cnt_d  = '0;
    sum_d  = '0;
    colsum = '0;
    px     = '0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        if (row_ok[r] && col_ok[c]) begin
          cnt_d = cnt_d + CntW'(1);
        end
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      for (int c = 0; c < 3; c++) begin
        colsum = '0;
        for (int r = 0; r < 3; r++) begin
          px = win[c][r];
          if (row_ok[r] && col_ok[c]) begin
            colsum = colsum + SumW'(px[ch]);
          end
        end
        sum_d[ch] = sum_d[ch] + colsum;
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      num[ch] = {b1_sum_q[ch], 1'b0} + NumW'(b1_cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
      b2_v_q <= 1'b0;
    end else begin
      b1_v_q <= job_pop_o;
      b2_v_q <= b1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      b1_sum_q  <= sum_d;
      b1_cnt_q  <= cnt_d;
      b1_last_q <= job_i.last;
    end
    if (b1_v_q) begin
      for (int ch = 0; ch < 3; ch++) begin
        b2_prod_q[ch] <= ProdW'(num[ch]) * ProdW'(recip(b1_cnt_q));
      end
      b2_last_q <= b1_last_q;
    end
  end

  always_comb begin
    res_o.blue_out      = b2_prod_q[0][RecipShift +: 8];
    res_o.green_out     = b2_prod_q[1][RecipShift +: 8];
    res_o.red_out       = b2_prod_q[2][RecipShift +: 8];
    res_o.last_of_frame = b2_last_q;
  end

  assign res_push_o = b2_v_q;

endmodule

FILE: sv/box_blur_3x3_rgb.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb: streaming 3x3 box blur over 8-bit blue, green, red pixels
// Pixels enter in raster order; each output is the rounded mean of the
// in-image neighbours of one pixel position, one row plus one pixel behind.
// ----------------------------------------------------------------------------
// Usage. Items are pushed with push while full is low; each transfer is a
// pixel or a drain tick (req_type set). After the last pixel of a frame the
// host pushes width+1 drain ticks to flush the final row of results. Results
// are read as from a queue: while empty is low, res_o holds the oldest result
// and a transfer happens when pop is high. The last result of a frame carries
// last_of_frame, after which the next item starts a new frame.
// Configuration writes (width, height) go through cfg_valid_i/cfg_ready_o;
// ready is always high, a write restarts the frame position, and writes are
// expected only while the block is idle.
// Throughput is one item per clock while full is low. Each item reads and
// rewrites one word of the line buffer RAM, a single-port-pair memory indexed
// by column, so the column sequence never stalls. A result reaches res_o
// through the lookup stage, the window queue, the sum stage and the
// reciprocal multiply stage, then the output queue write. Frames lag the
// input stream by width+1 items.
// Reset clears all counters and both queues and sets width and height to
// 1024; line buffer contents are not cleared and need no clearing pass.
// When pop stays low the output queue fills, the back end stops taking
// windows, the window queue fills and full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb import bblur_pkg::*; #(
  parameter int MAX_WIDTH  = MaxWidth,
  parameter int MAX_HEIGHT = MaxHeight
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                push,
  input  req_t                req_i,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output res_t                res_o
);

  cfg_wr_t              cfg_wr;
  logic                 job_push, job_pop, job_empty;
  job_t                 job_in, job_out;
  logic [QueueCntW-1:0] q_count;
  logic [OutCntW-1:0]   o_count;
  logic                 res_push;
  res_t                 res_in;

  // Config always accepted; user keeps block idle whenever used, unchecked.
  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  // Front end: counters, line buffers and the sliding window.
  bblur_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_wr),
    .push_i    (push),
    .req_i     (req_i),
    .full_o    (full),
    .q_count_i (q_count),
    .job_push_o(job_push),
    .job_o     (job_in)
  );

  // Windows waiting for the arithmetic; it lets each side stall on its own.
  bblur_fifo #(
    .Width($bits(job_t)),
    .Depth(QueueDepth)
  ) u_job_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (job_in),
    .pop_i  (job_pop),
    .data_o (job_out),
    .empty_o(job_empty),
    .full_o (),
    .count_o(q_count)
  );

  // Back end: masked sums and the rounded division.
  bblur_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(!job_empty),
    .job_i      (job_out),
    .job_pop_o  (job_pop),
    .o_count_i  (o_count),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  // Finished results; the receiver drains this queue at its own pace.
  bblur_fifo #(
    .Width($bits(res_t)),
    .Depth(OutDepth)
  ) u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .pop_i  (pop),
    .data_o (res_o),
    .empty_o(empty),
    .full_o (),
    .count_o(o_count)
  );

endmodule

FILE: tb/tb_box_blur_3x3_rgb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_rgb: self-checking bench for the streaming 3x3 box blur
// Pushes pixel frames and drain ticks through the input queue, pops the
// blurred pixels at random and compares each field against an in-bench
// prediction of the rounded neighbourhood means and the end-of-frame flag.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_rgb;
  import bblur_pkg::*;

  // Meaning of the req_type bit of an input transfer.
  localparam logic ReqPixel = 1'b0;
  localparam logic ReqDrain = 1'b1;

  // Register indexes that the block does not decode; writes to them must be
  // ignored and must not restart the frame.
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  // The pixel history spans two rows plus the 3x3 window at the widest image.
  localparam int unsigned HistDepth = 2 * MaxWidth + 3;

  localparam int unsigned RandomItems = 990;
  // Cycles to let pass after the last result before touching the registers,
  // so that items which produce nothing have left the pipeline.
  localparam int unsigned SettleCycles = 16;
  // About 2100 items in the worst case, each slowed by the heaviest stalls,
  // plus the waits between frames: far below this.
  localparam int unsigned CycleLimit = 500_000;

  typedef enum logic {RowWrite, RowItem} row_kind_e;

  // One line of the directed stimulus. A typed row carries the blurred pixel
  // that its transfer must produce; other rows rely on the prediction.
  typedef struct {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] val;
    req_t                item;
    bit                  typed;
    res_t                want;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                push = 1'b0;
  req_t                req_i = '0;
  logic                full;
  logic                empty;
  logic                pop = 1'b0;
  res_t                res_o;

  // Predicted state of the block: register copies, pixel history and the
  // input and output positions inside the current frame.
  logic [CfgDataW-1:0] width_reg;
  logic [CfgDataW-1:0] height_reg;
  pixel_t              line_hist [HistDepth];
  int unsigned         hist_wr;
  int unsigned         in_row;
  int unsigned         in_col;
  int unsigned         out_row;
  int unsigned         out_col;

  // Blurred pixels predicted but not yet popped, oldest first.
  res_t                blurred_due [$];
  res_t                due_px;

  int unsigned         send_idle = 14;
  int unsigned         recv_idle = 65;
  int unsigned         items_sent = 0;
  int unsigned         frames_sent = 0;
  int unsigned         writes_done = 0;
  int unsigned         pixels_checked = 0;
  int unsigned         mismatches = 0;
  int unsigned         cycle_count = 0;

  stim_row_t           stim_rows [$];

  box_blur_3x3_rgb uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .req_i       (req_i),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Out-of-range sizes are used clamped: zero behaves as one, anything above
  // the maximum as the maximum.
  function automatic int unsigned clamp_size(input logic [CfgDataW-1:0] v,
                                             input int unsigned hi);
    if (v == '0) return 1;
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  function automatic void restart_position();
    in_row  = 0;
    in_col  = 0;
    out_row = 0;
    out_col = 0;
  endfunction

  // Advances the predicted block by one accepted transfer. Returns 1 when
  // the transfer completes a window, with the blurred pixel in px_out.
  function automatic bit predict_blur(input req_t item, output res_t px_out);
    int unsigned w;
    int unsigned h;
    int unsigned cnt;
    int unsigned slot;
    int unsigned sum_b;
    int unsigned sum_g;
    int unsigned sum_r;
    int          dr;
    int          dc;
    int          back;
    pixel_t      px;
    pixel_t      v;
    bit          emit;
    w = clamp_size(width_reg, MaxWidth);
    h = clamp_size(height_reg, MaxHeight);
    // Drain ticks, and pixels past the last row, enter the history as black.
    px = '0;
    if (item.req_type == ReqPixel && in_row < h) begin
      px.blue  = item.blue_in;
      px.green = item.green_in;
      px.red   = item.red_in;
    end
    line_hist[hist_wr] = px;
    // The output trails the input by one row plus one pixel.
    emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    px_out = '0;
    if (emit) begin
      sum_b = 0;
      sum_g = 0;
      sum_r = 0;
      cnt   = 0;
      for (dr = -1; dr <= 1; dr++) begin
        for (dc = -1; dc <= 1; dc++) begin
          if (int'(out_row) + dr >= 0 && int'(out_row) + dr < int'(h) &&
              int'(out_col) + dc >= 0 && int'(out_col) + dc < int'(w)) begin
            back  = int'(w) + 1 - dr * int'(w) - dc;
            slot  = (hist_wr + HistDepth - int'(back)) % HistDepth;
            v     = line_hist[slot];
            sum_b += 32'(v.blue);
            sum_g += 32'(v.green);
            sum_r += 32'(v.red);
            cnt++;
          end
        end
      end
      // Mean rounded half up, exact in integers.
      px_out.blue_out      = 8'((2 * sum_b + cnt) / (2 * cnt));
      px_out.green_out     = 8'((2 * sum_g + cnt) / (2 * cnt));
      px_out.red_out       = 8'((2 * sum_r + cnt) / (2 * cnt));
      px_out.last_of_frame = (out_row == h - 1) && (out_col == w - 1);
    end
    hist_wr = (hist_wr + 1) % HistDepth;
    if (emit && px_out.last_of_frame) begin
      restart_position();
      return 1'b1;
    end
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (emit) begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    return emit;
  endfunction

  function automatic logic [7:0] rand_channel();
    int unsigned pick;
    pick = $urandom_range(7);
    if (pick == 0) return 8'd0;
    if (pick == 1) return 8'd255;
    return 8'($urandom_range(255));
  endfunction

  function automatic stim_row_t mk_write(input logic [CfgIdxW-1:0] idx,
                                         input logic [CfgDataW-1:0] val);
    stim_row_t row;
    row       = '{kind: RowWrite, idx: idx, val: val, item: '0, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic stim_row_t mk_item(input logic kind, input logic [7:0] b,
                                        input logic [7:0] g, input logic [7:0] r);
    stim_row_t row;
    row = '{kind: RowItem, idx: '0, val: '0, item: {kind, b, g, r}, typed: 1'b0,
            want: '0};
    return row;
  endfunction

  function automatic stim_row_t mk_want(input logic kind, input logic [7:0] b,
                                        input logic [7:0] g, input logic [7:0] r,
                                        input logic [7:0] wb, input logic [7:0] wg,
                                        input logic [7:0] wr, input logic last);
    stim_row_t row;
    row       = mk_item(kind, b, g, r);
    row.typed = 1'b1;
    row.want  = {wb, wg, wr, last};
    return row;
  endfunction

  // One register transfer. With more set, valid stays high for a following
  // write, so that valid is never dropped and raised in the same step.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx,
                           input logic [CfgDataW-1:0] val, input bit more);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (!more) cfg_valid_i <= 1'b0;
    writes_done++;
    if (idx == CfgImageWidth) begin
      width_reg = val;
      restart_position();
    end else if (idx == CfgImageHeight) begin
      height_reg = val;
      restart_position();
    end
  endtask

  // Pushes one item after a random gap and records what it must produce.
  // A typed expectation takes the place of the predicted pixel.
  task automatic push_item(input req_t item, input bit typed, input res_t want);
    res_t guess;
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push  <= 1'b1;
    req_i <= item;
    do @(posedge clk_i); while (full);
    items_sent++;
    if (predict_blur(item, guess)) blurred_due.push_back(typed ? want : guess);
  endtask

  // Holds the sender until every predicted pixel has been popped, then lets
  // the pipeline run dry before registers may be touched.
  task automatic wait_quiet();
    push <= 1'b0;
    while (blurred_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One frame at the current size: width*height items, mostly pixels with a
  // few drain ticks mixed in, then width+1 flushing items, some of them
  // pixels that must be treated as drains. A frame may be cut short.
  task automatic send_frame(input bit may_cut, output bit cut);
    int unsigned w;
    int unsigned h;
    int unsigned n_pix;
    int unsigned n_all;
    int unsigned stop_at;
    int unsigned k;
    req_t        item;
    w       = clamp_size(width_reg, MaxWidth);
    h       = clamp_size(height_reg, MaxHeight);
    n_pix   = w * h;
    n_all   = n_pix + w + 1;
    stop_at = n_all;
    cut     = 1'b0;
    if (may_cut && $urandom_range(9) == 0) begin
      stop_at = $urandom_range(n_all - 1);
      cut     = 1'b1;
    end
    for (k = 0; k < stop_at; k++) begin
      item.blue_in  = rand_channel();
      item.green_in = rand_channel();
      item.red_in   = rand_channel();
      if (k < n_pix) item.req_type = ($urandom_range(19) == 0) ? ReqDrain : ReqPixel;
      else           item.req_type = ($urandom_range(3) == 0) ? ReqPixel : ReqDrain;
      push_item(item, 1'b0, '0);
    end
    frames_sent++;
  endtask

  // New frame size. Mostly small images; now and then a zero size, a wider
  // one, or a single column with an oversized height. Both sizes are
  // rewritten whenever the current image is large, to keep frames short.
  task automatic pick_sizes();
    logic [CfgDataW-1:0] wv;
    logic [CfgDataW-1:0] hv;
    int unsigned         sel;
    int unsigned         mode;
    wv   = width_reg;
    hv   = height_reg;
    mode = $urandom_range(2);
    if (clamp_size(width_reg, MaxWidth) > 40 || clamp_size(height_reg, MaxHeight) > 8)
      mode = 2;
    if (mode != 1) begin
      sel = $urandom_range(99);
      if (sel < 5)       wv = '0;
      else if (sel < 10) wv = CfgDataW'($urandom_range(13, 40));
      else               wv = CfgDataW'($urandom_range(1, 12));
    end
    if (mode != 0) begin
      sel = $urandom_range(99);
      if (clamp_size(wv, MaxWidth) == 1 && sel < 4) hv = CfgDataW'($urandom_range(1025, 2047));
      else if (sel < 10)                            hv = '0;
      else                                          hv = CfgDataW'($urandom_range(1, 8));
    end
    if ($urandom_range(7) == 0)
      write_reg(CfgIdxW'($urandom_range(CfgSpareLo, CfgSpareHi)),
                CfgDataW'($urandom_range(2047)), 1'b1);
    if (mode == 0) begin
      write_reg(CfgImageWidth, wv, 1'b0);
    end else if (mode == 1) begin
      write_reg(CfgImageHeight, hv, 1'b0);
    end else begin
      write_reg(CfgImageWidth, wv, 1'b1);
      write_reg(CfgImageHeight, hv, 1'b0);
    end
  endtask

  // Result side: every popped pixel is checked field by field against the
  // oldest prediction. The pop request is redrawn on every edge.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (blurred_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected blurred pixel b=%0d g=%0d r=%0d last=%0b",
                   res_o.blue_out, res_o.green_out, res_o.red_out,
                   res_o.last_of_frame);
      end else begin
        due_px = blurred_due.pop_front();
        pixels_checked++;
        if (res_o.blue_out !== due_px.blue_out ||
            res_o.green_out !== due_px.green_out ||
            res_o.red_out !== due_px.red_out ||
            res_o.last_of_frame !== due_px.last_of_frame) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Pixel %0d: expected b=%0d g=%0d r=%0d last=%0b, got b=%0d g=%0d r=%0d last=%0b",
                     pixels_checked, due_px.blue_out, due_px.green_out,
                     due_px.red_out, due_px.last_of_frame, res_o.blue_out,
                     res_o.green_out, res_o.red_out, res_o.last_of_frame);
        end
      end
    end
    pop <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d blurred pixels still due",
               cycle_count, blurred_due.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int unsigned random_from;
    bit          cut;
    res_t        none;

    none = '0;

    // Right after reset only the width is set, so the height keeps its reset
    // value: the start of a one-column frame of 1024 rows, left unfinished.
    stim_rows.push_back(mk_write(CfgImageWidth, 11'd1));
    repeat (40)
      stim_rows.push_back(mk_item(ReqPixel, rand_channel(), rand_channel(),
                                  rand_channel()));
    // Single column, one mixed-colour pixel, then corner cases of a 1x1
    // frame: a drain tick inside the frame reads as black, and pixels sent
    // after the last one are ignored.
    stim_rows.push_back(mk_write(CfgImageWidth, 11'd0));
    stim_rows.push_back(mk_write(CfgImageHeight, 11'd0));
    stim_rows.push_back(mk_item(ReqPixel, 8'd255, 8'd0, 8'd128));
    stim_rows.push_back(mk_item(ReqDrain, 8'd0, 8'd0, 8'd0));
    stim_rows.push_back(mk_want(ReqDrain, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd128, 1'b1));
    stim_rows.push_back(mk_item(ReqDrain, 8'd77, 8'd77, 8'd77));
    stim_rows.push_back(mk_item(ReqPixel, 8'd255, 8'd255, 8'd255));
    stim_rows.push_back(mk_want(ReqPixel, 8'd18, 8'd52, 8'd86, 8'd0, 8'd0, 8'd0, 1'b1));
    // A 3x2 all-white frame: every mean is full scale, borders included.
    stim_rows.push_back(mk_write(CfgImageWidth, 11'd3));
    stim_rows.push_back(mk_write(CfgImageHeight, 11'd2));
    repeat (4) stim_rows.push_back(mk_item(ReqPixel, 8'd255, 8'd255, 8'd255));
    repeat (2)
      stim_rows.push_back(mk_want(ReqPixel, 8'd255, 8'd255, 8'd255,
                                  8'd255, 8'd255, 8'd255, 1'b0));
    repeat (3)
      stim_rows.push_back(mk_want(ReqDrain, 8'd0, 8'd0, 8'd0,
                                  8'd255, 8'd255, 8'd255, 1'b0));
    stim_rows.push_back(mk_want(ReqDrain, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b1));
    // A 2x2 frame of mixed values, checked by prediction.
    stim_rows.push_back(mk_write(CfgImageWidth, 11'd2));
    stim_rows.push_back(mk_item(ReqPixel, 8'd0, 8'd1, 8'd255));
    stim_rows.push_back(mk_item(ReqPixel, 8'd1, 8'd0, 8'd254));
    stim_rows.push_back(mk_item(ReqPixel, 8'd1, 8'd1, 8'd0));
    stim_rows.push_back(mk_item(ReqPixel, 8'd2, 8'd3, 8'd255));
    repeat (3) stim_rows.push_back(mk_item(ReqDrain, 8'd0, 8'd0, 8'd0));

    width_reg  = ImageSizeReset;
    height_reg = ImageSizeReset;
    hist_wr    = 0;
    restart_position();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == RowWrite) begin
        wait_quiet();
        write_reg(stim_rows[i].idx, stim_rows[i].val, 1'b0);
      end else begin
        push_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].want);
      end
    end

    // Random frames in three stretches: receiver mostly stalled, sender
    // mostly idle, then full speed on both sides. A cut frame is always
    // followed by a register write, which restarts the frame position.
    random_from = items_sent;
    cut         = 1'b1;
    while (items_sent - random_from < RandomItems) begin
      if (items_sent - random_from < RandomItems / 3) begin
        send_idle = 14;
        recv_idle = 65;
      end else if (items_sent - random_from < 2 * RandomItems / 3) begin
        send_idle = 65;
        recv_idle = 14;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (cut || $urandom_range(1) == 0) begin
        wait_quiet();
        pick_sizes();
      end
      send_frame(1'b1, cut);
    end

    wait_quiet();
    if (blurred_due.size() != 0) mismatches += blurred_due.size();

    $display("Pushed %0d items (%0d random) in %0d frames with %0d register writes.",
             items_sent, items_sent - random_from, frames_sent, writes_done);
    $display("Compared %0d blurred pixels, %0d mismatches.", pixels_checked, mismatches);
    if (mismatches == 0 && none == '0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: box_blur_3x3_rgb.f
sv/bblur_pkg.sv
sv/bblur_ram.sv
sv/bblur_fifo.sv
sv/bblur_front.sv
sv/bblur_back.sv
sv/box_blur_3x3_rgb.sv
tb/tb_box_blur_3x3_rgb.sv
